// ----- design/pee_pkg.sv -----
// Package: shared types and constants for the postfix expression evaluator.
`timescale 1ns / 1ps
package pee_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } pee_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               underflow_seen;
    logic               overflow_seen;
    logic               divide_by_zero_seen;
    logic               empty_at_end;
  } pee_out_t;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } pee_op_t;

  // Decoded request handed from the front end to the back end
  typedef struct packed {
    pee_op_t     op;
    logic [31:0] imm;
    logic        last;
  } pee_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP1,
    ST_POP2,
    ST_EXEC,
    ST_DIV,
    ST_PUSH,
    ST_EMIT,
    ST_OUT
  } pee_state_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [31:0] POP_EMPTY = 32'hFFFF_FFFF;

endpackage

// ----- design/postfix_expression_evaluator_unit.sv -----
// Top level of the postfix expression evaluator.
`timescale 1ns / 1ps
// Evaluates reverse Polish expressions one symbol per request. The front end
// decodes symbols into a two-entry queue; the back end runs a stack held in a
// memory of STACK_DEPTH words. In the back end + and - pop two operands,
// compute and push; * also waits for the registered multiplier, / for the
// bit-serial divider (one quotient bit a cycle). A final symbol emits the
// result into the output register, which holds it while out_stall is high.
module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pee_pkg::pee_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pee_pkg::pee_out_t out_data
);
  import pee_pkg::*;

  logic     cmd_valid, cmd_take;
  pee_cmd_t cmd_data;

  pee_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_data(cmd_data)
  );

  pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_data(cmd_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );
endmodule

// ----- design/pee_front.sv -----
// Front end: accepts symbols, classifies them and queues decoded requests.
`timescale 1ns / 1ps
module pee_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pee_pkg::pee_in_t  in_data,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output pee_pkg::pee_cmd_t cmd_data
);
  import pee_pkg::*;

  // two-entry queue
  pee_cmd_t   q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  pee_cmd_t   dec;
  logic       push, pop;

  // classify
  always_comb begin
    dec.last = in_data.end_of_expression;
    dec.imm  = {24'd0, in_data.symbol} - {24'd0, CH_ZERO};
    unique case (in_data.symbol)
      CH_PLUS:  dec.op = OP_ADD;
      CH_MINUS: dec.op = OP_SUB;
      CH_STAR:  dec.op = OP_MUL;
      CH_SLASH: dec.op = OP_DIV;
      default:  dec.op = OP_PUSH;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd_data  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end
endmodule

// ----- design/pee_div.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pee_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import pee_pkg::*;

  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[31]} - {1'b0, den_r};
    if (start) begin
      rem_nxt  = 32'd0;
      quo_nxt  = dividend[31] ? (32'd0 - dividend) : dividend;
      den_nxt  = divisor[31] ? (32'd0 - divisor) : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  assign done     = busy_r && (cnt_r == 6'd31);
  assign quotient = neg_r ? (32'd0 - quo_nxt) : quo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end
endmodule

// ----- design/pee_back.sv -----
// Back end: stack memory, arithmetic sequencer and result register.
`timescale 1ns / 1ps
module pee_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  pee_pkg::pee_cmd_t cmd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pee_pkg::pee_out_t out_data
);
  import pee_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  pee_state_t st_r, st_nxt;
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0] flg_r, flg_nxt; // {divz, over, under}
  pee_cmd_t cmd_r;
  logic [31:0] rgt_r, rgt_nxt, lft_r, lft_nxt, res_r, res_nxt;
  logic [31:0] prod_r;
  logic        mul_wait_r, mul_wait_nxt;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        ov_r, ov_nxt;
  pee_out_t    obuf_r, obuf_nxt;

  pee_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(lft_r), .divisor(rgt_r), .done(div_done), .quotient(div_q)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (cmd_valid) st_nxt = (cmd_data.op == OP_PUSH) ? ST_PUSH : ST_POP1;
      ST_POP1: st_nxt = ST_POP2;
      ST_POP2: st_nxt = ST_EXEC;
      ST_EXEC: begin
        if (cmd_r.op == OP_DIV && rgt_r != 32'd0) st_nxt = ST_DIV;
        else if (cmd_r.op == OP_MUL && !mul_wait_r) st_nxt = ST_EXEC;
        else st_nxt = ST_PUSH;
      end
      ST_DIV:  if (div_done) st_nxt = ST_PUSH;
      ST_PUSH: st_nxt = cmd_r.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: st_nxt = ST_OUT;
      ST_OUT:  if (!ov_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt      = cnt_r;
    flg_nxt      = flg_r;
    rgt_nxt      = rgt_r;
    lft_nxt      = lft_r;
    res_nxt      = res_r;
    mul_wait_nxt = 1'b0;
    cmd_take     = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = AW'(cnt_r - CW'(1));
    wr_en        = 1'b0;
    div_start    = 1'b0;
    ov_nxt       = ov_r && out_stall;
    obuf_nxt     = obuf_r;
    unique case (st_r)
      ST_IDLE: begin
        cmd_take = cmd_valid && !(ov_r && out_stall);
        if (cmd_valid) res_nxt = cmd_data.imm;
        if (cmd_valid && cmd_data.op != OP_PUSH && cnt_r != '0) rd_en = 1'b1;
      end
      ST_POP1: begin
        if (cnt_r == '0) begin
          rgt_nxt = POP_EMPTY;
          flg_nxt[0] = 1'b1;
        end else begin
          rgt_nxt = rd_r;
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r != CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = AW'(cnt_r - CW'(2));
          end
        end
      end
      ST_POP2: begin
        if (cnt_r == '0) begin
          lft_nxt = POP_EMPTY;
          flg_nxt[0] = 1'b1;
        end else begin
          lft_nxt = rd_r;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_EXEC: begin
        mul_wait_nxt = (cmd_r.op == OP_MUL);
        case (cmd_r.op)
          OP_ADD: res_nxt = lft_r + rgt_r;
          OP_SUB: res_nxt = lft_r - rgt_r;
          OP_MUL: res_nxt = prod_r;
          OP_DIV: begin
            res_nxt = 32'd0;
            if (rgt_r == 32'd0) flg_nxt[2] = 1'b1;
            else div_start = 1'b1;
          end
          default: res_nxt = res_r;
        endcase
      end
      ST_DIV: if (div_done) res_nxt = div_q;
      ST_PUSH: begin
        if (cnt_r == FULL) flg_nxt[1] = 1'b1;
        else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        if (cmd_r.last && cnt_r != FULL) begin
          rd_en = 1'b0;
        end
      end
      ST_EMIT: begin
        if (cnt_r != '0) rd_en = 1'b1;
      end
      ST_OUT: begin
        if (!ov_r) begin
          obuf_nxt.value               = (cnt_r == '0) ? 32'sd0 : $signed(rd_r);
          obuf_nxt.empty_at_end        = (cnt_r == '0);
          obuf_nxt.underflow_seen      = flg_r[0];
          obuf_nxt.overflow_seen       = flg_r[1];
          obuf_nxt.divide_by_zero_seen = flg_r[2];
          ov_nxt  = 1'b1;
          cnt_nxt = '0;
          flg_nxt = 3'd0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = obuf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      cnt_r      <= '0;
      flg_r      <= 3'd0;
      ov_r       <= 1'b0;
      mul_wait_r <= 1'b0;
    end else begin
      st_r       <= (st_r == ST_IDLE && !cmd_take) ? ST_IDLE : st_nxt;
      cnt_r      <= cnt_nxt;
      flg_r      <= flg_nxt;
      ov_r       <= ov_nxt;
      mul_wait_r <= mul_wait_nxt;
    end
  end

  // stack memory and payload registers
  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(cnt_r)] <= res_r;
    if (rd_en) rd_r <= mem[rd_addr];
    if (cmd_take) cmd_r <= cmd_data;
    prod_r <= lft_r * rgt_r;
    rgt_r  <= rgt_nxt;
    lft_r  <= lft_nxt;
    res_r  <= res_nxt;
    obuf_r <= obuf_nxt;
  end
endmodule

// ----- design/pee_checker.sv -----
// Port checker for the postfix expression evaluator, with its bind.
`timescale 1ns / 1ps
module pee_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input pee_pkg::pee_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input pee_pkg::pee_out_t out_data
);
  import pee_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_at_end |-> out_data.value == 32'sd0)
    else $error("empty stack gave nonzero value");

  // a stalled request stays put until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("control not cleared by reset");
endmodule

bind postfix_expression_evaluator_unit pee_checker u_pee_checker (.*);

// ----- bench/tb_postfix_expression_evaluator_unit.sv -----
// Testbench: postfix expression evaluator checked against a behavioural stack model.
`timescale 1ns / 1ps
module tb_postfix_expression_evaluator_unit;
  import pee_pkg::*;

  localparam int DEPTH = 16;
  localparam int SETTLE = 200;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pee_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pee_out_t out_data;

  postfix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Behavioural stack and sticky flags
  logic [31:0] stk [DEPTH];
  int          depth_now;
  logic        under_f, over_f, divz_f;
  pee_out_t    pending_results[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        done = 1'b0;

  function automatic logic [31:0] stack_pop();
    if (depth_now == 0) begin
      under_f = 1'b1;
      return POP_EMPTY;
    end
    depth_now--;
    return stk[depth_now];
  endfunction

  function automatic void stack_push(logic [31:0] v);
    if (depth_now >= DEPTH) begin
      over_f = 1'b1;
      return;
    end
    stk[depth_now] = v;
    depth_now++;
  endfunction

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Apply one accepted request to the model; queue a result on the last symbol
  function automatic void evaluate_symbol(pee_in_t r);
    logic [31:0] rhs, lhs, res;
    pee_out_t o;
    if (r.symbol inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
      rhs = stack_pop();
      lhs = stack_pop();
      case (r.symbol)
        CH_PLUS:  res = lhs + rhs;
        CH_MINUS: res = lhs - rhs;
        CH_STAR:  res = lhs * rhs;
        default: begin
          if (rhs == 0) begin
            divz_f = 1'b1;
            res = 0;
          end else res = trunc_div(lhs, rhs);
        end
      endcase
      stack_push(res);
    end else begin
      stack_push({24'd0, r.symbol} - {24'd0, CH_ZERO});
    end
    if (r.end_of_expression) begin
      o.value = (depth_now == 0) ? 32'sd0 : stk[depth_now - 1];
      o.empty_at_end = (depth_now == 0);
      o.underflow_seen = under_f;
      o.overflow_seen = over_f;
      o.divide_by_zero_seen = divz_f;
      pending_results.push_back(o);
      depth_now = 0;
      under_f = 1'b0;
      over_f = 1'b0;
      divz_f = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result monitor and random stall
  always @(posedge clk) begin
    pee_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0)
        report_mismatch("unexpected result", out_data.value, 32'd0);
      else begin
        w = pending_results.pop_front();
        if (out_data.value !== w.value) report_mismatch("value", out_data.value, w.value);
        if (out_data.underflow_seen !== w.underflow_seen)
          report_mismatch("underflow", 32'(out_data.underflow_seen),
                          32'(w.underflow_seen));
        if (out_data.overflow_seen !== w.overflow_seen)
          report_mismatch("overflow", 32'(out_data.overflow_seen),
                          32'(w.overflow_seen));
        if (out_data.divide_by_zero_seen !== w.divide_by_zero_seen)
          report_mismatch("divzero", 32'(out_data.divide_by_zero_seen),
                          32'(w.divide_by_zero_seen));
        if (out_data.empty_at_end !== w.empty_at_end)
          report_mismatch("empty", 32'(out_data.empty_at_end), 32'(w.empty_at_end));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Send one request, with an optional idle gap in front; waits for acceptance
  task automatic send_symbol(logic [7:0] s, logic eoe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{symbol: s, end_of_expression: eoe};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    evaluate_symbol('{symbol: s, end_of_expression: eoe});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_symbol();
    case ($urandom_range(9))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      4: return 8'($urandom_range(255));
      default: return 8'($urandom_range(8'h39, 8'h30));
    endcase
  endfunction

  // Directed rows: symbol, last flag, whether the result is typed in
  typedef struct {
    logic [7:0] s;
    logic       eoe;
    logic       fixed;
    pee_out_t   want;
  } row_t;

  row_t rows[$];

  function automatic void add_row(logic [7:0] s, logic eoe);
    rows.push_back('{s, eoe, 1'b0, '0});
  endfunction

  function automatic void add_fixed(logic [7:0] s, pee_out_t w);
    rows.push_back('{s, 1'b1, 1'b1, w});
  endfunction

  initial begin
    int n;
    depth_now = 0;
    under_f = 1'b0;
    over_f = 1'b0;
    divz_f = 1'b0;
    // Byte 0 alone gives -48; byte 255 alone gives 207
    add_fixed(8'h00, '{value: -32'sd48, default: 1'b0});
    add_fixed(8'hFF, '{value: 32'sd207, default: 1'b0});
    // Operator on an empty stack: both pops underflow, -1 + -1
    add_fixed(CH_PLUS, '{value: -32'sd2, underflow_seen: 1'b1, default: 1'b0});
    // Division by zero
    add_row(8'h37, 1'b0);
    add_row(CH_ZERO, 1'b0);
    add_fixed(CH_SLASH, '{value: 32'sd0, divide_by_zero_seen: 1'b1, default: 1'b0});
    // Truncation toward zero: -48 / 9, then minus 7, then times 3
    add_row(8'h00, 1'b0);
    add_row(8'h39, 1'b0);
    add_row(CH_SLASH, 1'b0);
    add_row(8'h37, 1'b0);
    add_row(CH_MINUS, 1'b0);
    add_row(8'h33, 1'b0);
    add_row(CH_STAR, 1'b1);
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    for (int i = 0; i < 17; i++) add_row(8'h39, 1'b0);
    add_fixed(8'h31, '{value: 32'sd9, overflow_seen: 1'b1, default: 1'b0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_symbol(rows[i].s, rows[i].eoe);
      if (rows[i].fixed) begin
        pending_results.pop_back();
        pending_results.push_back(rows[i].want);
      end
    end
    wait_drained();

    // Most negative over minus one: build -2^31 by repeated doubling
    send_symbol(8'h32, 1'b0);
    for (int i = 0; i < 30; i++) begin
      send_symbol(8'h32, 1'b0);
      send_symbol(CH_STAR, 1'b0);
    end
    // 0 - 1 gives the divisor -1
    send_symbol(CH_ZERO, 1'b0);
    send_symbol(8'h31, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_SLASH, 1'b1);
    // Every symbol ends with a push, so the stack is never empty at the end
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 57 : (ph == 3) ? 33 : 0;
      stall_pct = (ph == 2) ? 57 : (ph == 3) ? 33 : 0;
      n = 0;
      while (n < 500) begin
        int len;
        len = $urandom_range(20, 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) < 7)
            send_symbol((k % 2 == 1 && k > 0) ? random_symbol()
                        : 8'($urandom_range(8'h39, 8'h30)), k == len - 1);
          else send_symbol(random_symbol(), k == len - 1 || $urandom_range(19) == 0);
          n++;
        end
      end
      wait_drained();
    end
    stall_pct = 0;

    repeat (SETTLE) @(posedge clk);
    done = 1'b1;
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_postfix_expression_evaluator_unit: PASS");
    else
      $display("tb_postfix_expression_evaluator_unit: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    if (!done) begin
      $display("tb_postfix_expression_evaluator_unit: FAIL");
      $finish;
    end
  end

endmodule
